// ===== rtl/arw_pkg.sv =====
package arw_pkg;

  // Width of one bitmap word and of the packet counter.
  localparam int unsigned WORD_W = 64;
  localparam int unsigned BIT_W  = 6;

  // Address width that covers the largest window (4096 bits, 64 words).
  localparam int unsigned ARW_ADDR_W = 6;

  // Disposition codes.
  typedef logic [1:0] disp_t;
  localparam disp_t DISP_FRESH     = 2'd0;
  localparam disp_t DISP_DUPLICATE = 2'd1;
  localparam disp_t DISP_TOO_OLD   = 2'd2;

  // Control of the bitmap store for one cycle.
  typedef struct packed {
    logic                  rd_en;
    logic [ARW_ADDR_W-1:0] rd_addr;
    logic                  wr_en;
    logic [ARW_ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]     wr_data;
    logic                  clr;
  } mem_ctrl_t;

endpackage

// ===== rtl/arw_if.sv =====
interface arw_in_if import arw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [WORD_W-1:0] counter;

  modport source (output valid, input ready, output mode, output counter);
  modport sink   (input valid, output ready, input mode, input counter);
endinterface

interface arw_out_if import arw_pkg::*; ();
  logic              valid;
  logic              ready;
  disp_t             disposition;
  logic              committed;
  logic              window_ready;
  logic [WORD_W-1:0] highest_seen;

  modport source (output valid, input ready, output disposition, output committed,
                  output window_ready, output highest_seen);
  modport sink   (input valid, output ready, input disposition, input committed,
                  input window_ready, input highest_seen);
endinterface

// ===== rtl/arw_bitmap_ram.sv =====
module arw_bitmap_ram import arw_pkg::*; #(
  parameter int unsigned AW = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mem_ctrl_t         ctrl,
  output logic [WORD_W-1:0] rd_data
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r, valid_nxt;
  logic [WORD_W-1:0] rdata_r;
  logic              hit_r;

  logic [AW-1:0] rd_a;
  logic [AW-1:0] wr_a;

  assign rd_a = ctrl.rd_addr[AW-1:0];
  assign wr_a = ctrl.wr_addr[AW-1:0];

  // Word storage with a registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_a] <= ctrl.wr_data;
    end
    rdata_r <= mem[rd_a];
  end

  // A clear drops every flag; a write in the same cycle marks its word again.
  always_comb begin
    valid_nxt = ctrl.clr ? '0 : valid_r;
    if (ctrl.wr_en) begin
      valid_nxt[wr_a] = 1'b1;
    end
  end

  // One valid flag per word; a word never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= ctrl.rd_en && valid_r[rd_a];
    end
  end

  assign rd_data = hit_r ? rdata_r : '0;

endmodule

// ===== rtl/arw_funnel.sv =====
module arw_funnel import arw_pkg::*; (
  input  logic [WORD_W-1:0] hi,
  input  logic [WORD_W-1:0] lo,
  input  logic [BIT_W-1:0]  amount,
  output logic [WORD_W-1:0] result
);

  logic [2*WORD_W-1:0] joined;

  // Shift the word pair left and keep the upper word: the bits carried in
  // come from the top of the lower word.
  always_comb begin
    joined = {hi, lo} << amount;
    result = joined[2*WORD_W-1:WORD_W];
  end

endmodule

// ===== rtl/anti_replay_window_check_commit.sv =====
// Channel  Direction  Fields
// in_ch    sink       mode, counter
// out_ch   source     disposition, committed, window_ready, highest_seen
//
// A check, or a commit that needs no slide, passes from acceptance to the result register
// through the distance, word read, judge and output load steps.
// A commit that slides the bitmap adds an advance step and a word-by-word slide through the
// bitmap's read and write ports and the funnel shifter; an advance of a full window or more restarts it.
// Reset clears the window state and valid flags at once; no clearing pass is needed.
// in_ch is ready only while idle; a result waiting on out_ch stalls the next load.
module anti_replay_window_check_commit import arw_pkg::*; #(
  parameter int unsigned WINDOW_BITS = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  arw_in_if.sink   in_ch,
  arw_out_if.source out_ch
);

  localparam int unsigned WORDS = (WINDOW_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned IW    = $clog2(WORDS + 2);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIST  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_JUDGE = 7'b0001000,
    S_ADV   = 7'b0010000,
    S_SWEEP = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic              mode_r, mode_nxt;
  logic [WORD_W-1:0] counter_r, counter_nxt;
  logic [WORD_W-1:0] diff_r, diff_nxt;
  logic              above_r, above_nxt;
  logic [WORD_W-1:0] highest_r, highest_nxt;
  logic              started_r, started_nxt;
  disp_t             disp_r, disp_nxt;
  logic              com_r, com_nxt;
  logic [WORD_W-1:0] hi_r, hi_nxt;
  logic [IW-1:0]     i_r, i_nxt;

  logic              out_valid_r, out_valid_nxt;
  disp_t             out_disp_r, out_disp_nxt;
  logic              out_com_r, out_com_nxt;
  logic              out_ready_r, out_ready_nxt;
  logic [WORD_W-1:0] out_high_r, out_high_nxt;

  mem_ctrl_t         ctrl;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] shifted;

  logic [WORD_W-1:0] sub_a, sub_b;
  logic [WORD_W:0]   sub_res;
  logic              too_old;
  logic              seen;
  disp_t             judged;
  logic [AW-1:0]     lim;
  logic [IW-1:0]     dst_full;
  logic [AW-1:0]     dst;
  logic              out_free;

  // Shared subtractor: distance below the highest, or the advance above it.
  always_comb begin
    sub_a   = (state_r == S_ADV) ? counter_r : highest_r;
    sub_b   = (state_r == S_ADV) ? highest_r : counter_r;
    sub_res = {1'b0, sub_a} - {1'b0, sub_b};
  end

  // Classification from the registered distance and the word read back.
  always_comb begin
    too_old = diff_r >= WORD_W'(WINDOW_BITS);
    seen    = rd_data[diff_r[BIT_W-1:0]];
    if (!started_r || above_r) begin
      judged = DISP_FRESH;
    end else if (too_old) begin
      judged = DISP_TOO_OLD;
    end else if (seen) begin
      judged = DISP_DUPLICATE;
    end else begin
      judged = DISP_FRESH;
    end
  end

  // Slide addressing: reads walk down from the top source word; writes trail behind the reads.
  always_comb begin
    lim      = AW'(WORDS - 1) - diff_r[BIT_W +: AW];
    dst_full = IW'(WORDS + 1) - i_r;
    dst      = dst_full[AW-1:0];
  end

  arw_funnel u_funnel (
    .hi     (hi_r),
    .lo     (rd_data),
    .amount (diff_r[BIT_W-1:0]),
    .result (shifted)
  );

  arw_bitmap_ram #(
    .AW (AW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    counter_nxt = counter_r;
    diff_nxt    = diff_r;
    above_nxt   = above_r;
    highest_nxt = highest_r;
    started_nxt = started_r;
    disp_nxt    = disp_r;
    com_nxt     = com_r;
    hi_nxt      = hi_r;
    i_nxt       = i_r;
    ctrl        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt    = in_ch.mode;
          counter_nxt = in_ch.counter;
          state_nxt   = S_DIST;
        end
      end
      S_DIST: begin
        diff_nxt  = sub_res[WORD_W-1:0];
        above_nxt = sub_res[WORD_W];
        state_nxt = S_READ;
      end
      S_READ: begin
        ctrl.rd_en   = 1'b1;
        ctrl.rd_addr = ARW_ADDR_W'(diff_r[BIT_W +: AW]);
        state_nxt    = S_JUDGE;
      end
      S_JUDGE: begin
        disp_nxt  = judged;
        com_nxt   = mode_r && (judged == DISP_FRESH);
        state_nxt = S_DONE;
        if (mode_r && (judged == DISP_FRESH)) begin
          if (!started_r) begin
            // First commit starts the window.
            ctrl.clr     = 1'b1;
            ctrl.wr_en   = 1'b1;
            ctrl.wr_data = WORD_W'(1);
            highest_nxt  = counter_r;
            started_nxt  = 1'b1;
          end else if (!above_r) begin
            // Inside the window: mark the counter's bit.
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = ARW_ADDR_W'(diff_r[BIT_W +: AW]);
            ctrl.wr_data = rd_data | (WORD_W'(1) << diff_r[BIT_W-1:0]);
          end else begin
            state_nxt = S_ADV;
          end
        end
      end
      S_ADV: begin
        diff_nxt  = sub_res[WORD_W-1:0];
        i_nxt     = '0;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        if (too_old) begin
          // Advance of a full window or more: start over with bit 0 alone.
          ctrl.clr     = 1'b1;
          ctrl.wr_en   = 1'b1;
          ctrl.wr_data = WORD_W'(1);
          highest_nxt  = counter_r;
          state_nxt    = S_DONE;
        end else begin
          if (IW'(lim) >= i_r) begin
            ctrl.rd_en   = 1'b1;
            ctrl.rd_addr = ARW_ADDR_W'(AW'(IW'(lim) - i_r));
          end
          hi_nxt = rd_data;
          if (i_r >= IW'(2)) begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = ARW_ADDR_W'(dst);
            ctrl.wr_data = shifted | ((dst == '0) ? WORD_W'(1) : '0);
          end
          i_nxt = i_r + IW'(1);
          if (i_r == IW'(WORDS + 1)) begin
            highest_nxt = counter_r;
            state_nxt   = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register: loaded as the sequencer leaves its final state.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_disp_nxt  = out_disp_r;
    out_com_nxt   = out_com_r;
    out_ready_nxt = out_ready_r;
    out_high_nxt  = out_high_r;
    if ((state_r == S_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
      out_disp_nxt  = disp_r;
      out_com_nxt   = com_r;
      out_ready_nxt = started_r;
      out_high_nxt  = highest_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      highest_r   <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      highest_r   <= highest_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    counter_r  <= counter_nxt;
    diff_r     <= diff_nxt;
    above_r    <= above_nxt;
    disp_r     <= disp_nxt;
    com_r      <= com_nxt;
    hi_r       <= hi_nxt;
    out_disp_r <= out_disp_nxt;
    out_com_r  <= out_com_nxt;
    out_ready_r <= out_ready_nxt;
    out_high_r <= out_high_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.disposition  = out_disp_r;
  assign out_ch.committed    = out_com_r;
  assign out_ch.window_ready = out_ready_r;
  assign out_ch.highest_seen = out_high_r;

  // A commit is only ever reported for a fresh counter, and leaves the window started.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.committed |-> (out_ch.disposition == DISP_FRESH) && out_ch.window_ready)
    else $error("commit reported for a non-fresh counter or unstarted window");

  // After a transaction is taken the block is busy in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while the previous item was still in progress");

  // The slide never runs past its last destination word.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> (i_r <= IW'(WORDS + 1)))
    else $error("slide step counter out of range");

  // Once started, the window stays started.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(started_r) |-> started_r)
    else $error("window lost its started flag");

endmodule
